// ===== hw/rtl/vlds_pkg.sv =====
// shared types and constants for the value list delete and successor block
package vlds_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 7;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_DELETE = 2'd1,
        OP_SUCC   = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FINISH
    } vlds_state_t;

    typedef struct packed {
        status_t              status;
        logic [COUNT_W-1:0]   count;
        logic [VALUE_W-1:0]   value;
    } vlds_result_t;

endpackage

// ===== hw/rtl/value_list_delete_and_successor.sv =====
// top level: bounded value table with append, delete and successor search
//
// Requests enter on the s_ channel: s_tuser carries the request kind (append,
// delete first match, successor query) and s_tdata the value or key. Each
// request yields exactly one transfer on the m_ channel: m_tuser carries the
// status (done, miss, full), m_tdata the successor value (zero unless a query
// finds one) and the entry count after the request.
// The table lives in one ram of CAPACITY slots, each a valid bit and a value,
// with registered read. A request scans the slots one per cycle in order;
// append writes the first free slot and delete the first matching one, each
// stopping there, and a successor query reads every slot. One request is
// handled at a time; the next is taken as soon as m_tvalid rises.
// After reset a clearing pass writes every slot invalid, during which s_tready
// stays low. The result sits in an output register, so a stalled receiver does
// not block acceptance of the next request; the sequencer holds its finished
// result until that register is free.
module value_list_delete_and_successor
    import vlds_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] result_value, [38:32] entry_count, [39] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int IDX_W = $clog2(CAPACITY);

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [VALUE_W:0]   ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [VALUE_W:0]   ram_rdata;

    logic               res_valid;
    logic               res_ready;
    vlds_result_t       res;

    logic               m_tvalid_reg, m_tvalid_next;
    vlds_result_t       out_reg, out_next;

    vlds_ram #(
        .WIDTH (VALUE_W + 1),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    vlds_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (op_t'(s_tuser)),
        .in_value  (s_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            out_next      = res;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_reg.count, out_reg.value};
    assign m_tuser  = out_reg.status;

endmodule

// ===== hw/rtl/vlds_ram.sv =====
// generic single write, single read ram with registered read data
module vlds_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/vlds_ctrl.sv =====
// request sequencer: clearing pass, slot scan with read-modify-write, result build
module vlds_ctrl
    import vlds_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  op_t                         in_op,
    input  logic [VALUE_W-1:0]          in_value,
    output logic                        res_valid,
    input  logic                        res_ready,
    output vlds_result_t                res,
    output logic                        ram_we,
    output logic [$clog2(CAPACITY)-1:0] ram_waddr,
    output logic [VALUE_W:0]            ram_wdata,
    output logic                        ram_re,
    output logic [$clog2(CAPACITY)-1:0] ram_raddr,
    input  logic [VALUE_W:0]            ram_rdata
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W:0]   CAP_L  = (IDX_W + 1)'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_L = IDX_W'(CAPACITY - 1);

    vlds_state_t state_reg, state_next;
    op_t                op_reg, op_next;
    logic [VALUE_W-1:0] key_reg, key_next;
    logic [IDX_W:0]     issue_cnt_reg, issue_cnt_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               have_reg, have_next;
    logic [VALUE_W-1:0] best_reg, best_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    status_t            status_reg, status_next;
    logic [VALUE_W-1:0] res_value_reg, res_value_next;

    logic               slot_valid;
    logic [VALUE_W-1:0] slot_value;
    logic               hit;
    logic               scan_end;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    assign slot_valid = ram_rdata[VALUE_W];
    assign slot_value = ram_rdata[VALUE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            issue_cnt_reg <= '0;
            cmp_vld_reg   <= 1'b0;
            have_reg      <= 1'b0;
            count_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            cmp_vld_reg   <= cmp_vld_next;
            have_reg      <= have_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        cmp_idx_reg   <= cmp_idx_next;
        best_reg      <= best_next;
        status_reg    <= status_next;
        res_value_reg <= res_value_next;
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        issue_cnt_next = issue_cnt_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        have_next      = have_reg;
        best_next      = best_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        res_value_next = res_value_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = cmp_idx_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = issue_cnt_reg[IDX_W-1:0];
        hit            = 1'b0;
        scan_end       = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = issue_cnt_reg[IDX_W-1:0];
                if (issue_cnt_reg[IDX_W-1:0] == LAST_L) begin
                    issue_cnt_next = '0;
                    state_next     = S_IDLE;
                end else begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next        = in_op;
                    key_next       = in_value;
                    issue_cnt_next = '0;
                    have_next      = 1'b0;
                    best_next      = '0;
                    res_value_next = '0;
                    unique case (in_op) inside
                        OP_APPEND, OP_DELETE, OP_SUCC: state_next = S_SCAN;
                        default: begin
                            status_next = ST_MISS;
                            state_next  = S_FINISH;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // evaluate the slot whose read data arrived this cycle
                if (cmp_vld_reg) begin
                    unique case (op_reg)
                        OP_APPEND: begin
                            if (!slot_valid) begin
                                hit       = 1'b1;
                                ram_we    = 1'b1;
                                ram_wdata = {1'b1, key_reg};
                            end
                        end
                        OP_DELETE: begin
                            if (slot_valid && slot_value == key_reg) begin
                                hit       = 1'b1;
                                ram_we    = 1'b1;
                                ram_wdata = '0;
                            end
                        end
                        default: begin
                            if (slot_valid && $signed(slot_value) > $signed(key_reg) &&
                                (!have_reg || $signed(slot_value) < $signed(best_reg))) begin
                                have_next = 1'b1;
                                best_next = slot_value;
                            end
                        end
                    endcase
                    scan_end = hit || (cmp_idx_reg == LAST_L);
                end

                if (scan_end) begin
                    state_next = S_FINISH;
                    unique case (op_reg)
                        OP_APPEND: begin
                            status_next = hit ? ST_DONE : ST_FULL;
                            if (hit) begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_DELETE: begin
                            status_next = hit ? ST_DONE : ST_MISS;
                            if (hit) begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        default: begin
                            status_next    = have_next ? ST_DONE : ST_MISS;
                            res_value_next = have_next ? best_next : '0;
                        end
                    endcase
                end else if (issue_cnt_reg < CAP_L) begin
                    ram_re         = 1'b1;
                    cmp_vld_next   = 1'b1;
                    cmp_idx_next   = issue_cnt_reg[IDX_W-1:0];
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
            end
            S_FINISH: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // entry count carries its low bits only
    assign count_ext  = {{COUNT_W{1'b0}}, count_reg};
    assign res.status = status_reg;
    assign res.count  = count_ext[COUNT_W-1:0];
    assign res.value  = res_value_reg;

endmodule
